>>> rtl/wfm_pkg.sv
package wfm_pkg;

	localparam int FRAME_LEN = 64;
	localparam int FL_W = $clog2(FRAME_LEN);
	localparam int NBINS = FRAME_LEN / 2 + 1;
	localparam int BIN_W = 6;
	localparam int SMP_W = 16;
	localparam int TRIG_W = 17;
	localparam int SPEC_W = 24;
	localparam int POW_W = 48;
	localparam int DB_W = 16;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [27:0] DB_PER_LOG2_Q24 = 28'sd50504453;

	typedef logic signed [TRIG_W-1:0] tab_t [FRAME_LEN];

	typedef enum logic [3:0] {
		ST_FILL,
		ST_DFT,
		ST_DRAIN,
		ST_STORE,
		ST_MAG_RD,
		ST_MAG_SQ,
		ST_MAG_SUM,
		ST_LOG_GO,
		ST_LOG,
		ST_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		LG_IDLE,
		LG_NORM,
		LG_SQR,
		LG_MUL,
		LG_RND
	} log_state_t;

	typedef longint unsigned div_tab_t [7];
	localparam div_tab_t COS_DIV = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182};
	localparam div_tab_t SIN_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd1};

	// Q30 to Q15, round half up
	function automatic logic signed [TRIG_W-1:0] q30_to_q15(input longint v);
		longint r;
		r = (v + 64'sd16384) >>> 15;
		return r[TRIG_W-1:0];
	endfunction

	// Cosine and sine in Q15 of a 32-bit phase in turns; cos in upper half
	function automatic logic [2*TRIG_W-1:0] trig_of_phase(input longint unsigned t);
		longint unsigned r, th, x2, term;
		longint c, s, cq, sq;
		int q;
		q = int'((t >> 30) & 64'd3);
		r = t & 64'h3FFF_FFFF;
		th = (r * HALF_PI_Q30) >> 30;
		x2 = (th * th) >> 30;
		c = 64'sd1 <<< 30;
		term = 64'd1 << 30;
		for (int k = 0; k < 7; k++) begin
			term = ((term * x2) >> 30) / COS_DIV[k];
			if ((k % 2) == 0) c = c - longint'(term); else c = c + longint'(term);
		end
		s = longint'(th);
		term = th;
		for (int k = 0; k < 6; k++) begin
			term = ((term * x2) >> 30) / SIN_DIV[k];
			if ((k % 2) == 0) s = s - longint'(term); else s = s + longint'(term);
		end
		case (q)
			0: begin cq = c; sq = s; end
			1: begin cq = -s; sq = c; end
			2: begin cq = -c; sq = -s; end
			default: begin cq = s; sq = -c; end
		endcase
		return {q30_to_q15(cq), q30_to_q15(sq)};
	endfunction

	// Symmetric Hann window weights
	function automatic tab_t make_win();
		tab_t w;
		logic [2*TRIG_W-1:0] cs;
		longint unsigned t;
		longint cv;
		for (int n = 0; n < FRAME_LEN; n++) begin
			t = (longint'(n % (FRAME_LEN - 1)) << 32) / (FRAME_LEN - 1);
			cs = trig_of_phase(t);
			cv = longint'($signed(cs[2*TRIG_W-1:TRIG_W]));
			w[n] = TRIG_W'((64'sd32768 - cv + 64'sd1) >>> 1);
		end
		return w;
	endfunction

	function automatic tab_t make_cos();
		tab_t w;
		logic [2*TRIG_W-1:0] cs;
		for (int n = 0; n < FRAME_LEN; n++) begin
			cs = trig_of_phase((longint'(n) << 32) / FRAME_LEN);
			w[n] = cs[2*TRIG_W-1:TRIG_W];
		end
		return w;
	endfunction

	function automatic tab_t make_sin();
		tab_t w;
		logic [2*TRIG_W-1:0] cs;
		for (int n = 0; n < FRAME_LEN; n++) begin
			cs = trig_of_phase((longint'(n) << 32) / FRAME_LEN);
			w[n] = cs[TRIG_W-1:0];
		end
		return w;
	endfunction

	localparam tab_t WIN_TAB = make_win();
	localparam tab_t COS_TAB = make_cos();
	localparam tab_t SIN_TAB = make_sin();

endpackage

>>> rtl/wfm_ram.sv
module wfm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/wfm_log_db.sv
module wfm_log_db
	import wfm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [POW_W-1:0]         power,
	output logic                     done,
	output logic signed [DB_W-1:0]   db
);

	log_state_t state_q, state_d;
	logic [POW_W-1:0] pn_q;
	logic [5:0] e_q;
	logic [30:0] m_q;
	logic [15:0] frac_q;
	logic [3:0] cnt_q;
	logic signed [50:0] prod_q;
	logic done_q;
	logic signed [DB_W-1:0] db_q;

	logic [61:0] sq;
	logic [31:0] sq_top;
	logic signed [6:0] e_off;
	logic signed [22:0] lg;
	logic [50:0] mag;
	logic [18:0] rnd;
	logic signed [19:0] db_full;

	assign sq = 62'(m_q) * 62'(m_q);
	assign sq_top = sq[61:30];
	assign e_off = $signed({1'b0, e_q}) - 7'sd30;
	assign lg = $signed({e_off, frac_q});
	assign mag = prod_q[50] ? 51'(-prod_q) : 51'(prod_q);
	assign rnd = 19'((mag + 51'd2147483648) >> 32);
	assign db_full = prod_q[50] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

	// Advance the log state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == LG_RND) || (state_q == LG_IDLE && start && power == '0);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			LG_IDLE: if (start && power != '0) state_d = LG_NORM;
			LG_NORM: if (pn_q[POW_W-1]) state_d = LG_SQR;
			LG_SQR:  if (cnt_q == 4'd15) state_d = LG_MUL;
			LG_MUL:  state_d = LG_RND;
			LG_RND:  state_d = LG_IDLE;
			default: state_d = LG_IDLE;
		endcase
	end

	// Normalize, square for fraction bits, scale to dB, round and saturate
	always_ff @(posedge clk) begin
		case (state_q)
			LG_IDLE: begin
				pn_q <= power;
				e_q <= 6'(POW_W - 1);
				if (start && power == '0) db_q <= 16'sh8000;
			end
			LG_NORM: begin
				if (pn_q[POW_W-1]) begin
					m_q <= pn_q[POW_W-1:POW_W-31];
					cnt_q <= '0;
					frac_q <= '0;
				end else begin
					pn_q <= pn_q << 1;
					e_q <= e_q - 6'd1;
				end
			end
			LG_SQR: begin
				m_q <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
				frac_q <= {frac_q[14:0], sq_top[31]};
				cnt_q <= cnt_q + 4'd1;
			end
			LG_MUL: prod_q <= 51'(lg) * 51'(DB_PER_LOG2_Q24);
			LG_RND: begin
				if (db_full > 20'sd32767) db_q <= 16'sh7FFF;
				else if (db_full < -20'sd32768) db_q <= 16'sh8000;
				else db_q <= db_full[15:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign db = db_q;

endmodule

>>> rtl/windowed_fft_magnitude_spectrum_core.sv
// Takes one item per cycle while filling 64 samples; input stalls from the 64th item on.
// Each of 33 bins is a 64-term multiply-accumulate, then a pipeline drain and a store.
// The dB stage then converts each bin's power by a bit-serial normalize and 16 squaring
// steps; a zero power skips both and gives the lowest dB code.
// Reset clears the fill count and control; sample and spectrum memories are not cleared.
module windowed_fft_magnitude_spectrum_core
	import wfm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [SMP_W-1:0] sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [BIN_W-1:0]        bin_index,
	output logic signed [DB_W-1:0]  magnitude_db,
	output logic                    last_bin
);

	top_state_t state_q, state_d;
	logic [FL_W-1:0] fill_q, n_q, ph_q;
	logic [BIN_W-1:0] k_q;
	logic v_s1, v_s2, v_s3, last_s1, last_s2, last_s3;
	logic [FL_W-1:0] n_s1, ph_s1;
	logic signed [32:0] x_s2;
	logic signed [TRIG_W-1:0] c_s2, sn_s2;
	logic signed [49:0] pr_s3, pi_s3;
	logic signed [55:0] acc_re_q, acc_im_q, rnd_re, rnd_im;
	logic signed [47:0] re2_q, im2_q;
	logic [POW_W-1:0] p_q;
	logic out_valid_q, last_q;
	logic [BIN_W-1:0] bin_q;
	logic signed [DB_W-1:0] db_out_q;

	logic in_acc;
	logic [SMP_W-1:0] smp_rd;
	logic [2*SPEC_W-1:0] spec_rd;
	logic signed [SPEC_W-1:0] re_rd, im_rd;
	logic log_done;
	logic signed [DB_W-1:0] log_db;

	assign in_stall = (state_q != ST_FILL);
	assign in_acc = in_valid && !in_stall;
	assign re_rd = spec_rd[2*SPEC_W-1:SPEC_W];
	assign im_rd = spec_rd[SPEC_W-1:0];
	assign rnd_re = (acc_re_q + 56'sd536870912) >>> 30;
	assign rnd_im = (acc_im_q + 56'sd536870912) >>> 30;

	wfm_ram #(.WIDTH(SMP_W), .DEPTH(FRAME_LEN)) u_smp_ram (
		.clk     (clk),
		.wr_en   (in_acc),
		.wr_addr (fill_q),
		.wr_data (sample),
		.rd_en   (state_q == ST_DFT),
		.rd_addr (n_q),
		.rd_data (smp_rd)
	);

	wfm_ram #(.WIDTH(2*SPEC_W), .DEPTH(NBINS)) u_spec_ram (
		.clk     (clk),
		.wr_en   (state_q == ST_STORE),
		.wr_addr (k_q),
		.wr_data ({rnd_re[SPEC_W-1:0], rnd_im[SPEC_W-1:0]}),
		.rd_en   (state_q == ST_MAG_RD),
		.rd_addr (k_q),
		.rd_data (spec_rd)
	);

	wfm_log_db u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_LOG_GO),
		.power  (p_q),
		.done   (log_done),
		.db     (log_db)
	);

	// Sequence fill, transform and per-bin output
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL:    if (in_acc && fill_q == FL_W'(FRAME_LEN - 1)) state_d = ST_DFT;
			ST_DFT:     if (n_q == FL_W'(FRAME_LEN - 1)) state_d = ST_DRAIN;
			ST_DRAIN:   if (v_s3 && last_s3) state_d = ST_STORE;
			ST_STORE:   state_d = (k_q == BIN_W'(NBINS - 1)) ? ST_MAG_RD : ST_DFT;
			ST_MAG_RD:  state_d = ST_MAG_SQ;
			ST_MAG_SQ:  state_d = ST_MAG_SUM;
			ST_MAG_SUM: state_d = ST_LOG_GO;
			ST_LOG_GO:  state_d = ST_LOG;
			ST_LOG:     if (log_done) state_d = ST_OUT;
			ST_OUT: begin
				if (!out_stall) state_d = (k_q == BIN_W'(NBINS - 1)) ? ST_FILL : ST_MAG_RD;
			end
			default:    state_d = ST_FILL;
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q <= '0;
			n_q <= '0;
			ph_q <= '0;
			k_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= (state_q == ST_DFT);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			case (state_q)
				ST_FILL: begin
					if (in_acc) fill_q <= fill_q + FL_W'(1);
					n_q <= '0;
					ph_q <= '0;
					k_q <= '0;
				end
				ST_DFT: begin
					n_q <= n_q + FL_W'(1);
					ph_q <= ph_q + FL_W'(k_q);
				end
				ST_STORE: begin
					n_q <= '0;
					ph_q <= '0;
					k_q <= (k_q == BIN_W'(NBINS - 1)) ? '0 : k_q + BIN_W'(1);
				end
				ST_LOG: if (log_done) out_valid_q <= 1'b1;
				ST_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						k_q <= (k_q == BIN_W'(NBINS - 1)) ? '0 : k_q + BIN_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Advance the multiply-accumulate pipeline, form bin power and register the output
	always_ff @(posedge clk) begin
		n_s1 <= n_q;
		ph_s1 <= ph_q;
		last_s1 <= (n_q == FL_W'(FRAME_LEN - 1));
		x_s2 <= $signed(smp_rd) * WIN_TAB[n_s1];
		c_s2 <= COS_TAB[ph_s1];
		sn_s2 <= SIN_TAB[ph_s1];
		last_s2 <= last_s1;
		pr_s3 <= x_s2 * c_s2;
		pi_s3 <= x_s2 * sn_s2;
		last_s3 <= last_s2;
		if (state_q == ST_STORE || state_q == ST_FILL) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s3) begin
			acc_re_q <= acc_re_q + 56'(pr_s3);
			acc_im_q <= acc_im_q - 56'(pi_s3);
		end
		if (state_q == ST_MAG_SQ) begin
			re2_q <= 48'(re_rd) * 48'(re_rd);
			im2_q <= 48'(im_rd) * 48'(im_rd);
		end
		if (state_q == ST_MAG_SUM) p_q <= POW_W'(re2_q) + POW_W'(im2_q);
		if (state_q == ST_LOG && log_done) begin
			db_out_q <= log_db;
			bin_q <= k_q;
			last_q <= (k_q == BIN_W'(NBINS - 1));
		end
	end

	assign out_valid = out_valid_q;
	assign bin_index = bin_q;
	assign magnitude_db = db_out_q;
	assign last_bin = last_q;

endmodule

>>> sim/tb_windowed_fft_magnitude_spectrum_core.sv
`timescale 1ns / 1ps

module tb_windowed_fft_magnitude_spectrum_core;
	import wfm_pkg::*;

	localparam int IDLE_LIMIT = 40000;
	localparam int RAND_FRAMES = 4;

	typedef struct {
		logic [BIN_W-1:0]       bin;
		logic signed [DB_W-1:0] db;
		logic                   last;
	} bin_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [SMP_W-1:0] sample = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [BIN_W-1:0]        bin_index;
	logic signed [DB_W-1:0]  magnitude_db;
	logic                    last_bin;

	logic signed [SMP_W-1:0] pending_samples[$];
	bin_result_t             bins_due[$];
	shortint                 frame_buf[FRAME_LEN];
	int                      frame_fill = 0;
	int                      hann_w[FRAME_LEN];
	longint                  tw_cos[FRAME_LEN];
	longint                  tw_sin[FRAME_LEN];
	int                      errors = 0;
	int                      samples_taken = 0;
	int                      bins_seen = 0;
	int                      idle_cycles = 0;
	int                      in_gap = 0;
	int                      out_hold = 0;
	bit                      in_burst = 0;
	bit                      out_burst = 0;
	bit                      in_taken = 0;

	windowed_fft_magnitude_spectrum_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bin_index(bin_index),
		.magnitude_db(magnitude_db),
		.last_bin(last_bin)
	);

	always #10 clk = ~clk;

	// Cosine and sine in Q15 of the phase num/den turns, Taylor series in Q30
	task automatic phase_cos_sin(input longint unsigned num, input longint unsigned den,
			output longint cq, output longint sq);
		longint unsigned ph, r, th, x2, term;
		longint c, s, c4, s4;
		int quad;
		ph = ((num % den) << 32) / den;
		quad = int'((ph >> 30) & 64'd3);
		r = ph & 64'h3FFF_FFFF;
		th = (r * 64'd1686629713) >> 30;
		x2 = (th * th) >> 30;
		c = 64'sd1 <<< 30;
		term = 64'd1 << 30;
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
			if (k % 2) c = c - longint'(term); else c = c + longint'(term);
		end
		s = longint'(th);
		term = th;
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2) s = s - longint'(term); else s = s + longint'(term);
		end
		case (quad)
			0: begin c4 = c; s4 = s; end
			1: begin c4 = -s; s4 = c; end
			2: begin c4 = -c; s4 = -s; end
			default: begin c4 = s; s4 = -c; end
		endcase
		cq = (c4 + 64'sd16384) >>> 15;
		sq = (s4 + 64'sd16384) >>> 15;
	endtask

	// Power in Q30 to dB in Q7.8 through a bit-serial log2
	function automatic logic signed [DB_W-1:0] power_db(input longint unsigned pw);
		int e;
		longint unsigned m, mag, rnd;
		longint frac, lg, prod, db;
		if (pw == 0) return -16'sd32768;
		e = 63;
		while (e > 0 && pw[e] == 1'b0) e--;
		if (e >= 30) m = pw >> (e - 30); else m = pw << (30 - e);
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		lg = longint'(e - 30) * 65536 + frac;
		prod = lg * 64'sd50504453;
		mag = prod < 0 ? longint'(-prod) : longint'(prod);
		rnd = (mag + (64'd1 << 31)) >> 32;
		db = prod < 0 ? -longint'(rnd) : longint'(rnd);
		if (db > 32767) db = 32767;
		if (db < -32768) db = -32768;
		return DB_W'(db);
	endfunction

	// Store one sample; on a full frame queue the spectrum it produces
	task automatic fold_sample(input logic signed [SMP_W-1:0] smp);
		longint wx[FRAME_LEN];
		longint are, aim, re, im;
		bin_result_t r;
		frame_buf[frame_fill] = smp;
		frame_fill++;
		if (frame_fill < FRAME_LEN) return;
		frame_fill = 0;
		for (int n = 0; n < FRAME_LEN; n++)
			wx[n] = longint'(frame_buf[n]) * longint'(hann_w[n]);
		for (int k = 0; k <= FRAME_LEN / 2; k++) begin
			are = 0;
			aim = 0;
			for (int n = 0; n < FRAME_LEN; n++) begin
				are = are + wx[n] * tw_cos[(k * n) % FRAME_LEN];
				aim = aim - wx[n] * tw_sin[(k * n) % FRAME_LEN];
			end
			re = (are + (64'sd1 <<< 29)) >>> 30;
			im = (aim + (64'sd1 <<< 29)) >>> 30;
			r.bin = BIN_W'(k);
			r.db = power_db(longint'(re * re + im * im));
			r.last = (k == FRAME_LEN / 2);
			bins_due.push_back(r);
		end
	endtask

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Drive samples at the falling edge with random gaps; advance only after an accept
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_taken)
				in_gap = in_burst ? 0 : $urandom_range(0, 15);
			in_taken = 0;
			if ($urandom_range(0, 59) == 0)
				in_burst = ~in_burst;
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				sample <= pending_samples.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Drive result backpressure, a fresh hold count per item
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				out_hold = out_burst ? 0 : $urandom_range(0, 15);
			if ($urandom_range(0, 79) == 0)
				out_burst = ~out_burst;
			if (out_hold > 0) begin
				out_hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Sample handshakes at the rising edge, check results, watch for hangs
	always @(posedge clk) begin
		bin_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_taken = 1;
				fold_sample(sample);
				samples_taken++;
			end
			if (out_valid && !out_stall) begin
				bins_seen++;
				if (bins_due.size() == 0) begin
					flag_mismatch("unexpected bin_index", bin_index, -1);
				end else begin
					want = bins_due.pop_front();
					if (bin_index !== want.bin) flag_mismatch("bin_index", bin_index, want.bin);
					if (magnitude_db !== want.db)
						flag_mismatch("magnitude_db", magnitude_db, want.db);
					if (last_bin !== want.last) flag_mismatch("last_bin", last_bin, want.last);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("windowed_fft_magnitude_spectrum_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		longint cv, sv;
		int mode, amp;
		for (int n = 0; n < FRAME_LEN; n++) begin
			phase_cos_sin(n, FRAME_LEN - 1, cv, sv);
			hann_w[n] = int'((64'sd32768 - cv + 1) >>> 1);
			phase_cos_sin(n, FRAME_LEN, cv, sv);
			tw_cos[n] = cv;
			tw_sin[n] = sv;
		end

		// Silent frame gives zero power, the lowest dB code, in every bin
		for (int n = 0; n < FRAME_LEN; n++) pending_samples.push_back(16'sd0);
		// Alternating full scale lands on the Nyquist bin
		for (int n = 0; n < FRAME_LEN; n++)
			pending_samples.push_back(n % 2 ? -16'sd32768 : 16'sd32767);
		// Random frames: full range, a random power-of-two amplitude, or a constant level
		for (int f = 0; f < RAND_FRAMES; f++) begin
			mode = $urandom_range(0, 2);
			amp = 1 << $urandom_range(0, 14);
			cv = $urandom_range(0, 65535);
			for (int n = 0; n < FRAME_LEN; n++)
				case (mode)
					0: pending_samples.push_back(SMP_W'($urandom));
					1: pending_samples.push_back(SMP_W'(int'($urandom_range(0, 2 * amp)) - amp));
					default: pending_samples.push_back(SMP_W'(cv));
				endcase
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_samples.size() == 0 && !in_valid);
		wait (bins_due.size() == 0);
		repeat (200) @(posedge clk);

		$display("covered %0d samples in %0d frames and checked %0d bins",
			samples_taken, samples_taken / FRAME_LEN, bins_seen);
		$display("frames: silence, alternating full scale, random levels and constants");
		if (errors == 0)
			$display("windowed_fft_magnitude_spectrum_core verification clean");
		else
			$display("windowed_fft_magnitude_spectrum_core verification failed");
		$finish;
	end

endmodule
